@@ rtl/core/tfds_pkg.sv @@
// tfds_pkg: shared types, phase codes, register indexes and constants
// for the tank fill/drain sequencer; no dependencies
package tfds_pkg;

    // phase codes
    localparam logic [2:0] PH_EMPTY       = 3'd0;
    localparam logic [2:0] PH_FILLING     = 3'd1;
    localparam logic [2:0] PH_FULL        = 3'd2;
    localparam logic [2:0] PH_DISCHARGING = 3'd3;
    localparam logic [2:0] PH_EMERGENCY   = 3'd4;
    localparam logic [2:0] PH_RESTART     = 3'd5;

    // configuration register indexes
    localparam int          CFG_IDX_W            = 2;
    localparam logic [1:0]  CFG_LEAK_MODE        = 2'd0;
    localparam logic [1:0]  CFG_REFILL_MODE      = 2'd1;
    localparam logic [1:0]  CFG_SAFETY_VOL       = 2'd2;
    localparam logic [1:0]  CFG_DS_SAFETY_VOL    = 2'd3;
    localparam int          CFG_DATA_W           = 16;

    localparam logic signed [15:0] SAFETY_VOL_RESET = 16'sd16000;

    // leak duty curve
    localparam logic [31:0]        LEAK_START_TIME = 32'd7200;
    localparam logic signed [15:0] DUTY_HI_LEVEL   = 16'sd1600;
    localparam logic signed [15:0] DUTY_LO_LEVEL   = 16'sd480;
    localparam logic [7:0]         DUTY_OPEN       = 8'd255;
    localparam logic [7:0]         DUTY_CLOSED     = 8'd0;
    // floor(q / 5) = (q * 205) >> 10 for q below 850
    localparam logic [17:0]        DIV5_RECIP      = 18'd205;

    typedef struct packed {
        logic [31:0]        sim_time;
        logic               alarm;
        logic               restart_done;
        logic signed [15:0] tank_volume;
        logic signed [15:0] downstream_volume;
        logic [14:0]        drawn_target_volume;
        logic [15:0]        drawn_interval;
    } in_t;

    typedef struct packed {
        logic [2:0] state_code;
        logic [7:0] fill_duty;
        logic       drain_open;
        logic       emergency_flag;
    } out_t;

    typedef struct packed {
        logic               leak_mode;
        logic               refill_mode;
        logic signed [15:0] safety_volume;
        logic signed [15:0] downstream_safety_volume;
    } cfg_t;

endpackage

@@ rtl/core/tfds_duty.sv @@
// tfds_duty: leak-mode fill valve duty from the downstream volume
// depends on tfds_pkg
module tfds_duty (
    input  logic               leak_mode,
    input  logic [31:0]        sim_time,
    input  logic signed [15:0] downstream_volume,
    input  logic [7:0]         duty_cur,
    output logic [7:0]         duty_new
);
    import tfds_pkg::*;

    logic [10:0] d11;
    logic [14:0] x17;
    logic [9:0]  q;
    logic [17:0] m;

    // d * 255 / 2400 == d * 17 / 160: times 17, shift by 5, then divide by 5
    always_comb
    begin
        d11 = downstream_volume[10:0];
        x17 = {d11, 4'b0000} + {4'b0000, d11};
        q   = x17[14:5];
        m   = {8'b0, q} * DIV5_RECIP;
    end

    always_comb
    begin
        duty_new = duty_cur;
        if (leak_mode && (sim_time > LEAK_START_TIME))
        begin
            if (downstream_volume > DUTY_HI_LEVEL)
                duty_new = DUTY_OPEN;
            else if ((downstream_volume < DUTY_HI_LEVEL) && (downstream_volume > DUTY_LO_LEVEL))
                duty_new = m[17:10];
            else if (downstream_volume < DUTY_LO_LEVEL)
                duty_new = DUTY_CLOSED;
        end
    end

endmodule

@@ rtl/core/tfds_seq.sv @@
// tfds_seq: sequencer state registers and the one-pass phase chain
// depends on tfds_pkg and tfds_duty
module tfds_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  tfds_pkg::cfg_t cfg,
    input  tfds_pkg::in_t  item,
    output tfds_pkg::out_t result
);
    import tfds_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [14:0] target_reg, target_next;
    logic [31:0] move_time_reg, move_time_next;
    logic [7:0]  duty_reg, duty_next;

    logic [7:0]         open_duty;
    logic [7:0]         fill;
    logic               drain;
    logic               emerg;
    logic               redraw;
    logic               ready_ds;
    logic signed [16:0] vol_x;
    logic signed [16:0] tgt_x;
    logic signed [16:0] ds_sum;
    logic signed [16:0] ds_limit;

    tfds_duty u_duty (
        .leak_mode         (cfg.leak_mode),
        .sim_time          (item.sim_time),
        .downstream_volume (item.downstream_volume),
        .duty_cur          (duty_reg),
        .duty_new          (duty_next)
    );

    always_comb
    begin
        vol_x    = {item.tank_volume[15], item.tank_volume};
        tgt_x    = {2'b00, target_reg};
        ds_sum   = {item.downstream_volume[15], item.downstream_volume} + tgt_x;
        ds_limit = {cfg.downstream_safety_volume[15], cfg.downstream_safety_volume};
        ready_ds = ds_limit > ds_sum;
        open_duty = cfg.leak_mode ? duty_next : DUTY_OPEN;
    end

    // phase checks in fixed order, one tick may pass several phases
    always_comb
    begin
        phase_next = phase_reg;
        fill       = DUTY_CLOSED;
        drain      = 1'b0;
        emerg      = 1'b0;
        redraw     = 1'b0;

        if (item.alarm)
            phase_next = PH_EMERGENCY;
        if ((item.tank_volume >= cfg.safety_volume) && (phase_next != PH_RESTART))
            phase_next = PH_EMERGENCY;

        if (phase_next == PH_EMPTY)
        begin
            if ((item.sim_time >= move_time_reg) || cfg.refill_mode)
                phase_next = PH_FILLING;
        end
        if (phase_next == PH_FILLING)
        begin
            fill = open_duty;
            if ((vol_x >= tgt_x) && !cfg.leak_mode)
                phase_next = PH_FULL;
        end
        if (phase_next == PH_FULL)
        begin
            // valves shut while full, even when filling ended this tick
            fill = DUTY_CLOSED;
            if (ready_ds && ((item.sim_time >= move_time_reg) || !cfg.refill_mode))
                phase_next = PH_DISCHARGING;
        end
        if (phase_next == PH_DISCHARGING)
        begin
            fill  = DUTY_CLOSED;
            drain = 1'b1;
            if (item.tank_volume <= 16'sd0)
            begin
                phase_next = PH_EMPTY;
                redraw     = 1'b1;
            end
        end
        if (phase_next == PH_EMERGENCY)
        begin
            emerg = 1'b1;
            if (!item.alarm)
                phase_next = PH_RESTART;
        end
        else if (phase_next == PH_RESTART)
        begin
            fill  = open_duty;
            drain = 1'b1;
            if (item.restart_done)
            begin
                phase_next = PH_EMPTY;
                redraw     = 1'b1;
            end
        end

        target_next    = redraw ? item.drawn_target_volume : target_reg;
        move_time_next = redraw ? (move_time_reg + {16'b0, item.drawn_interval})
                                : move_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EMPTY;
            target_reg    <= '0;
            move_time_reg <= '0;
            duty_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            move_time_reg <= move_time_next;
            duty_reg      <= duty_next;
        end
    end

    always_comb
    begin
        result.state_code     = phase_next;
        result.fill_duty      = fill;
        result.drain_open     = drain;
        result.emergency_flag = emerg;
    end

    // a redraw only happens on the way back to empty
    a_redraw_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && redraw |-> phase_next == PH_EMPTY)
        else $error("redraw without return to empty");

    // move time only changes on a redraw
    a_move_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !redraw |=> $stable(move_time_reg))
        else $error("move time changed without redraw");

endmodule

@@ rtl/core/tank_fill_drain_sequencer.sv @@
// tank_fill_drain_sequencer: top level, input stage, config registers,
// result register; depends on tfds_pkg, tfds_seq
//
//  channel   direction  handshake               payload
//  in        in         in_valid / in_ready     in_data  (tfds_pkg::in_t)
//  out       out        out_valid / out_ready   out_data (tfds_pkg::out_t)
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
// one tick per cycle sustained while out_ready stays high: a transfer
// lands in the input register, the phase chain and duty update run in one
// combinational pass from there into the result register once that
// register is free or being drained, and out_valid rises once it is loaded
// rst_n is asynchronous; it clears valids, phase, target volume, move time,
// leak duty and restores the config reset values
// a stalled result holds the result register; the input register keeps one
// tick waiting behind it, then in_ready drops
module tank_fill_drain_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tfds_pkg::in_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tfds_pkg::out_t                       out_data,
    input  logic                                 cfg_we,
    input  logic [tfds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tfds_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tfds_pkg::*;

    cfg_t cfg_reg;

    // input stage
    logic s1_valid_reg;
    in_t  s1_data_reg;
    logic s1_fire;

    // result stage
    logic out_valid_reg;
    out_t out_data_reg;
    out_t step_result;

    // step runs when the result register is free or being drained
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // config writes, to be made only while idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leak_mode                <= 1'b0;
            cfg_reg.refill_mode              <= 1'b0;
            cfg_reg.safety_volume            <= SAFETY_VOL_RESET;
            cfg_reg.downstream_safety_volume <= SAFETY_VOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEAK_MODE:     cfg_reg.leak_mode                <= cfg_data[0];
                CFG_REFILL_MODE:   cfg_reg.refill_mode              <= cfg_data[0];
                CFG_SAFETY_VOL:    cfg_reg.safety_volume            <= cfg_data;
                CFG_DS_SAFETY_VOL: cfg_reg.downstream_safety_volume <= cfg_data;
                default:           cfg_reg                          <= cfg_reg;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

    tfds_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .cfg    (cfg_reg),
        .item   (s1_data_reg),
        .result (step_result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // emergency results keep both valves shut and sit in emergency or restart
    a_emerg_valves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.emergency_flag |->
            (out_data.fill_duty == DUTY_CLOSED) && !out_data.drain_open &&
            ((out_data.state_code == PH_EMERGENCY) || (out_data.state_code == PH_RESTART)))
        else $error("emergency result with a valve open");

    // outside leak mode the fill valve is either shut or fully open
    a_fill_binary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_reg.leak_mode |->
            (out_data.fill_duty == DUTY_CLOSED) || (out_data.fill_duty == DUTY_OPEN))
        else $error("partial fill duty outside leak mode");

    // a waiting tick in the input stage is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input stage lost a waiting tick");

    // the step only fires into a free result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !s1_fire)
        else $error("result overwritten while stalled");

endmodule

@@ tb/tfds_sequence_checker.sv @@
// tfds_sequence_checker: watches the in, out and config channels of the tank
// fill/drain sequencer, predicts every result and compares it field by field
// depends on tfds_pkg
`timescale 1ns / 1ps

module tfds_sequence_checker
    import tfds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_waiting,
    output int                    results_compared
);

    // shadow of the config registers
    logic        leak_on;
    logic        refill_on;
    int          own_limit;
    int          ds_limit;

    // shadow of the sequencer state
    logic [2:0]  tank_phase;
    logic [15:0] target_vol;
    logic [31:0] move_time;
    logic [7:0]  leak_duty;

    out_t        expected_valves[$];
    out_t        want;

    // one tick of the sequencer; updates the shadow state
    function automatic out_t run_tick(input in_t tk);
        int         vol;
        int         dvol;
        int         tgt;
        int         duty_calc;
        logic [7:0] open_duty;
        logic [7:0] fill;
        logic       drain;
        logic       emerg;
        logic       ds_ready;
        out_t       res;

        vol   = $signed(tk.tank_volume);
        dvol  = $signed(tk.downstream_volume);
        fill  = DUTY_CLOSED;
        drain = 1'b0;
        emerg = 1'b0;

        // leak duty holds its value exactly at either level
        if (leak_on && tk.sim_time > LEAK_START_TIME) begin
            if (dvol > DUTY_HI_LEVEL)
                leak_duty = DUTY_OPEN;
            else if (dvol < DUTY_HI_LEVEL && dvol > DUTY_LO_LEVEL) begin
                duty_calc = dvol * 255 / 2400;
                leak_duty = duty_calc[7:0];
            end
            else if (dvol < DUTY_LO_LEVEL)
                leak_duty = DUTY_CLOSED;
        end
        open_duty = leak_on ? leak_duty : DUTY_OPEN;

        if (tk.alarm)
            tank_phase = PH_EMERGENCY;
        if (vol >= own_limit && tank_phase != PH_RESTART)
            tank_phase = PH_EMERGENCY;

        // checks fall through in order, several moves per tick
        if (tank_phase == PH_EMPTY) begin
            fill  = DUTY_CLOSED;
            drain = 1'b0;
            if (tk.sim_time >= move_time || refill_on)
                tank_phase = PH_FILLING;
        end
        if (tank_phase == PH_FILLING) begin
            tgt   = target_vol;
            fill  = open_duty;
            drain = 1'b0;
            if (vol >= tgt && !leak_on)
                tank_phase = PH_FULL;
        end
        if (tank_phase == PH_FULL) begin
            tgt      = target_vol;
            ds_ready = ds_limit > dvol + tgt;
            fill     = DUTY_CLOSED;
            drain    = 1'b0;
            if (ds_ready && (tk.sim_time >= move_time || !refill_on))
                tank_phase = PH_DISCHARGING;
        end
        if (tank_phase == PH_DISCHARGING) begin
            fill  = DUTY_CLOSED;
            drain = 1'b1;
            if (vol <= 0) begin
                tank_phase = PH_EMPTY;
                target_vol = {1'b0, tk.drawn_target_volume};
                move_time  = move_time + tk.drawn_interval;
            end
        end
        if (tank_phase == PH_EMERGENCY) begin
            fill  = DUTY_CLOSED;
            drain = 1'b0;
            emerg = 1'b1;
            if (!tk.alarm)
                tank_phase = PH_RESTART;
        end
        else if (tank_phase == PH_RESTART) begin
            fill  = open_duty;
            drain = 1'b1;
            if (tk.restart_done) begin
                tank_phase = PH_EMPTY;
                target_vol = {1'b0, tk.drawn_target_volume};
                move_time  = move_time + tk.drawn_interval;
            end
        end

        res.state_code     = tank_phase;
        res.fill_duty      = fill;
        res.drain_open     = drain;
        res.emergency_flag = emerg;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", field, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            leak_on          = 1'b0;
            refill_on        = 1'b0;
            own_limit        = SAFETY_VOL_RESET;
            ds_limit         = SAFETY_VOL_RESET;
            tank_phase       = PH_EMPTY;
            target_vol       = '0;
            move_time        = '0;
            leak_duty        = DUTY_CLOSED;
            mismatch_count   = 0;
            results_compared = 0;
            expected_valves.delete();
            results_waiting  = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEAK_MODE:     leak_on   = cfg_data[0];
                    CFG_REFILL_MODE:   refill_on = cfg_data[0];
                    CFG_SAFETY_VOL:    own_limit = $signed(cfg_data);
                    CFG_DS_SAFETY_VOL: ds_limit  = $signed(cfg_data);
                    default: ;
                endcase
            end
            // result side first so an empty queue is never matched by a same-edge push
            if (out_valid && out_ready) begin
                if (expected_valves.size() == 0) begin
                    $error("out transfer with no result pending");
                    mismatch_count++;
                end
                else begin
                    want = expected_valves.pop_front();
                    compare_field("state_code", want.state_code, out_data.state_code);
                    compare_field("fill_duty", want.fill_duty, out_data.fill_duty);
                    compare_field("drain_open", want.drain_open, out_data.drain_open);
                    compare_field("emergency_flag", want.emergency_flag,
                                  out_data.emergency_flag);
                    results_compared++;
                end
            end
            if (in_valid && in_ready)
                expected_valves.push_back(run_tick(in_data));
            results_waiting = expected_valves.size();
        end
    end

endmodule

@@ tb/tank_fill_drain_sequencer_test.sv @@
// tank_fill_drain_sequencer_test: drives ticks and register writes into the
// sequencer under random idling on both sides and gives the verdict
// depends on tfds_pkg, tank_fill_drain_sequencer, tfds_sequence_checker
`timescale 1ns / 1ps

module tank_fill_drain_sequencer_test;

    import tfds_pkg::*;

    // generous: well above what the slowest legal run needs
    localparam int CYCLE_LIMIT = 300000;
    // long receiver hold, well past the two ticks the block can buffer
    localparam int LONG_HOLD   = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatch_count;
    int                    results_waiting;
    int                    results_compared;

    // stimulus bookkeeping
    logic                  quiet = 1'b0;     // no idling on either side
    int                    hold_reqs = 0;    // long receiver holds asked for
    int                    holds_done = 0;   // long receiver holds carried out
    logic [31:0]           sim_clock;        // running plant time for well-formed ticks
    int                    ticks_sent = 0;
    int                    settings_used = 0;
    int                    cycle_count = 0;

    always #4 clk = ~clk;

    tank_fill_drain_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tfds_sequence_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .results_waiting  (results_waiting),
        .results_compared (results_compared)
    );

    // hard stop on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tank_fill_drain_sequencer_test: errors");
            $finish;
        end
    end

    // build one tick from plain integers
    function automatic in_t make_tick(input logic [31:0] t, input logic alarm_b,
                                      input logic rdone_b, input int vol,
                                      input int dvol, input int tgt,
                                      input int interval);
        in_t tk;
        tk.sim_time            = t;
        tk.alarm               = alarm_b;
        tk.restart_done        = rdone_b;
        tk.tank_volume         = vol[15:0];
        tk.downstream_volume   = dvol[15:0];
        tk.drawn_target_volume = tgt[14:0];
        tk.drawn_interval      = interval[15:0];
        return tk;
    endfunction

    // mostly plausible plant ticks: time moving forward, volumes around the
    // fill, drain and duty thresholds; a few raw random ticks as noise
    function automatic in_t random_tick();
        logic [127:0] noise;
        int           vol;
        int           dvol;
        int           tgt;
        int           interval;

        if ($urandom_range(0, 99) < 6) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            return noise[$bits(in_t)-1:0];
        end
        sim_clock = sim_clock + $urandom_range(0, 4000);

        case ($urandom_range(0, 9))
            0, 1, 2:    vol = $urandom_range(0, 40) - 20;   // around drained
            3, 4, 5, 6: vol = $urandom_range(0, 5000);      // around target
            7, 8:       vol = $urandom_range(0, 20000);     // up to safety
            default:    vol = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dvol = $urandom_range(0, 2400);
            // right on or next to a duty level
            6:       dvol = ($urandom_range(0, 1) ? 1600 : 480) + $urandom_range(0, 2) - 1;
            7, 8:    dvol = $urandom_range(0, 300);
            default: dvol = $urandom;
        endcase
        tgt      = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5000) : $urandom;
        interval = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3000) : $urandom;

        return make_tick(sim_clock, $urandom_range(0, 99) < 4,
                         $urandom_range(0, 2) == 0, vol, dvol, tgt, interval);
    endfunction

    // offer one tick and hold it until the transfer, then maybe idle
    task automatic offer_tick(input in_t tk);
        in_data  <= tk;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic offer_random(input int count);
        repeat (count) offer_tick(random_tick());
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_waiting != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // write all four registers on back-to-back cycles; block is idle here
    task automatic configure(input logic leak, input logic refill,
                             input int own_lvl, input int ds_lvl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEAK_MODE;
        cfg_data  <= {15'd0, leak};
        @(posedge clk);
        cfg_index <= CFG_REFILL_MODE;
        cfg_data  <= {15'd0, refill};
        @(posedge clk);
        cfg_index <= CFG_SAFETY_VOL;
        cfg_data  <= own_lvl[15:0];
        @(posedge clk);
        cfg_index <= CFG_DS_SAFETY_VOL;
        cfg_data  <= ds_lvl[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // receiver: random stall bursts, long holds on request, none when quiet
    initial begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LEAK_MODE;
        cfg_data  <= '0;
        sim_clock  = 32'd70000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at reset settings
        // whole empty-fill-full-discharge-empty cycle inside one tick
        offer_tick(make_tick(0, 0, 0, 0, 0, 100, 50));
        // move time not reached, stays empty
        offer_tick(make_tick(10, 0, 0, 0, 0, 0, 0));
        offer_tick(make_tick(60, 0, 0, 50, 0, 0, 0));
        // full and on to discharging in one tick
        offer_tick(make_tick(70, 0, 0, 100, 0, 0, 0));
        // drained at the field extremes, largest redraw
        offer_tick(make_tick(80, 0, 0, -32768, 32767, 32767, 65535));
        // over own safety volume: emergency left for restart in the same tick
        offer_tick(make_tick(70000, 0, 0, 32767, 0, 0, 0));
        // restart ignores own volume
        offer_tick(make_tick(70001, 0, 0, 32767, -32768, 0, 0));
        offer_tick(make_tick(70002, 0, 1, 0, 0, 5, 10));
        // full but downstream not ready
        offer_tick(make_tick(70003, 0, 0, 5, 32767, 0, 0));
        offer_tick(make_tick(70004, 0, 0, 5, -32768, 0, 0));
        // alarm holds emergency, restart-done has no effect there
        offer_tick(make_tick(70005, 1, 0, 5, 0, 0, 0));
        offer_tick(make_tick(70006, 1, 1, 0, 0, 0, 0));
        offer_tick(make_tick(70007, 0, 0, 15999, 0, 0, 0));
        // alarm pulls restart back to emergency
        offer_tick(make_tick(70008, 1, 0, 0, 0, 0, 0));
        offer_tick(make_tick(70009, 0, 1, 16000, 0, 0, 0));
        offer_tick(make_tick(70010, 0, 1, 16000, 0, 0, 0));
        // time at its top
        offer_tick(make_tick(32'hFFFF_FFFF, 0, 0, 16000, 0, 0, 0));
        offer_tick(make_tick(32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0));

        // random at reset settings, with one long receiver hold so the
        // block fills up and drops in_ready while ticks keep coming
        hold_reqs++;
        offer_random(150);
        settle();

        // leak mode: duty curve edges, then random
        configure(1'b1, 1'b0, 16000, 16000);
        offer_tick(make_tick(7200, 0, 1, 0, 32767, 0, 0));   // at start time, no update
        offer_tick(make_tick(7201, 0, 0, 0, 1601, 0, 0));
        offer_tick(make_tick(7202, 0, 0, 0, 1600, 0, 0));    // on the level, holds
        offer_tick(make_tick(7203, 0, 0, 0, 1599, 0, 0));
        offer_tick(make_tick(7204, 0, 0, 0, 481, 0, 0));
        offer_tick(make_tick(7205, 0, 0, 0, 480, 0, 0));     // on the level, holds
        offer_tick(make_tick(7206, 0, 0, 0, 479, 0, 0));
        offer_tick(make_tick(7207, 0, 0, 0, 32767, 0, 0));
        offer_tick(make_tick(7208, 0, 0, 0, -32768, 0, 0));
        offer_random(150);
        settle();

        // refill mode, own threshold at top, downstream never ready
        configure(1'b0, 1'b1, 32767, -32768);
        hold_reqs++;
        offer_random(120);
        settle();

        // own threshold at bottom: emergency whenever not restarting
        configure(1'b0, 1'b0, -32768, 32767);
        offer_random(60);
        settle();

        // leak and refill together at mid thresholds
        configure(1'b1, 1'b1, 8000, 4000);
        offer_random(150);
        settle();

        // back to reset values, no idling to the end
        configure(1'b0, 1'b0, 16000, 16000);
        quiet = 1'b1;
        offer_random(170);

        settle();
        repeat (10) @(posedge clk);
        @(negedge clk);

        $display("covered %0d ticks over %0d register settings plus reset values",
                 ticks_sent, settings_used);
        $display("%0d results compared, %0d mismatches", results_compared, mismatch_count);
        if (mismatch_count == 0 && results_waiting == 0)
            $display("tank_fill_drain_sequencer_test: clean");
        else
            $display("tank_fill_drain_sequencer_test: errors");
        $finish;
    end

endmodule
